[hdl/tbpg_pkg.sv]
// Shared types, register codes and reset values of the tape block pulse generator.
package tbpg_pkg;

  // Request codes
  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IW = 3;
  localparam int unsigned CFG_DW = 24;
  localparam logic [CFG_IW-1:0] CFG_PILOT_LEN   = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_SYNC1_LEN   = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_SYNC2_LEN   = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_ZERO_LEN    = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_ONE_LEN     = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_PAUSE_LEN   = 3'd5;
  localparam logic [CFG_IW-1:0] CFG_HDR_PILOTS  = 3'd6;
  localparam logic [CFG_IW-1:0] CFG_DATA_PILOTS = 3'd7;

  // Register reset values
  localparam logic [15:0] RST_PILOT_LEN   = 16'd2168;
  localparam logic [15:0] RST_SYNC1_LEN   = 16'd667;
  localparam logic [15:0] RST_SYNC2_LEN   = 16'd735;
  localparam logic [15:0] RST_ZERO_LEN    = 16'd855;
  localparam logic [15:0] RST_ONE_LEN     = 16'd1710;
  localparam logic [23:0] RST_PAUSE_LEN   = 24'd3500000;
  localparam logic [13:0] RST_HDR_PILOTS  = 14'd8063;
  localparam logic [13:0] RST_DATA_PILOTS = 14'd3223;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        hdr_blk;
    logic [16:0] block_length;
    logic [15:0] byte_index;
    logic [7:0]  byte_value;
    logic [15:0] tick_cycles;
  } tbpg_req_t;

  typedef struct packed {
    logic ear_out;
    logic done_res;
  } tbpg_res_t;

  typedef struct packed {
    logic [15:0] pilot_pulse_len;
    logic [15:0] sync_first_len;
    logic [15:0] sync_second_len;
    logic [15:0] zero_bit_len;
    logic [15:0] one_bit_len;
    logic [23:0] pause_len;
    logic [13:0] header_pilot_count;
    logic [13:0] data_pilot_count;
  } tbpg_cfg_t;

endpackage

[hdl/tbpg_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tbpg_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/tbpg_core.sv]
// Pulse sequencer: block phases, pulse timing through one shared subtractor.
module tbpg_core
  import tbpg_pkg::*;
#(
  parameter int unsigned BLOCK_BYTES = 65536
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  tbpg_req_t                      req_i,
  output logic                           res_valid_o,
  output tbpg_res_t                      res_o,
  input  tbpg_cfg_t                      cfg_i,
  output logic [$clog2(BLOCK_BYTES)-1:0] rd_addr_o,
  input  logic [7:0]                     rd_data_i
);

  localparam int unsigned AW = $clog2(BLOCK_BYTES);
  localparam logic [16:0] MAX_LEN = 17'(BLOCK_BYTES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_TICK,
    S_RD,
    S_LD
  } state_e;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_PILOT = 3'd1,
    PH_SYNC1 = 3'd2,
    PH_SYNC2 = 3'd3,
    PH_DATA  = 3'd4,
    PH_PAUSE = 3'd5
  } phase_e;

  state_e      state_q, state_d;
  phase_e      phase_q, phase_d;
  logic [24:0] ptl_q, ptl_d;
  logic [13:0] pilot_q, pilot_d;
  logic [13:0] pilot_dec;
  logic [16:0] byte_pos_q, byte_pos_d;
  logic [16:0] block_len_q, block_len_d;
  logic [2:0]  bit_pos_q, bit_pos_d;
  logic        half_q, half_d;
  logic        level_q, level_d;
  logic        ear_q, ear_d;
  logic [15:0] delta_q, delta_d;
  logic        res_valid_q, res_valid_d;
  tbpg_res_t   res_q, res_d;

  // Shared unit: delta minus time left; sign says whether the pulse ends
  logic [25:0] diff;
  logic [25:0] neg;
  logic        crossing;

  assign diff     = {10'd0, delta_q} - {1'b0, ptl_q};
  assign neg      = ~diff + 26'd1;
  assign crossing = ~diff[25];
  assign pilot_dec = (pilot_q != 14'd0) ? pilot_q - 14'd1 : 14'd0;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    ptl_d       = ptl_q;
    pilot_d     = pilot_q;
    byte_pos_d  = byte_pos_q;
    block_len_d = block_len_q;
    bit_pos_d   = bit_pos_q;
    half_d      = half_q;
    level_d     = level_q;
    ear_d       = ear_q;
    delta_d     = delta_q;
    res_valid_d = 1'b0;
    res_d       = res_q;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (req_i.req_type)
            REQ_START: begin
              block_len_d = (req_i.block_length > MAX_LEN) ? MAX_LEN : req_i.block_length;
              byte_pos_d  = 17'd0;
              bit_pos_d   = 3'd7;
              half_d      = 1'b0;
              pilot_d     = req_i.hdr_blk ? cfg_i.header_pilot_count
                                          : cfg_i.data_pilot_count;
              if (pilot_d != 14'd0) begin
                phase_d = PH_PILOT;
                ptl_d   = {9'd0, cfg_i.pilot_pulse_len};
              end else begin
                phase_d = PH_SYNC1;
                ptl_d   = {9'd0, cfg_i.sync_first_len};
              end
              res_valid_d = 1'b1;
            end
            REQ_TICK: begin
              delta_d = req_i.tick_cycles;
              state_d = S_TICK;
            end
            default: begin
              // Byte writes go straight to the store; unknown codes only report
              res_valid_d = 1'b1;
            end
          endcase
        end
      end
      S_TICK: begin
        if (phase_q == PH_IDLE || !crossing) begin
          if (phase_q != PH_IDLE) begin
            ptl_d = neg[24:0];
          end
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else begin
          delta_d = diff[15:0];
          ptl_d   = 25'd0;
          unique case (phase_q)
            PH_PILOT: begin
              ear_d   = level_q;
              level_d = ~level_q;
              pilot_d = pilot_dec;
              if (pilot_dec != 14'd0) begin
                ptl_d = {9'd0, cfg_i.pilot_pulse_len};
              end else begin
                phase_d = PH_SYNC1;
                ptl_d   = {9'd0, cfg_i.sync_first_len};
              end
            end
            PH_SYNC1: begin
              ear_d   = level_q;
              level_d = ~level_q;
              phase_d = PH_SYNC2;
              ptl_d   = {9'd0, cfg_i.sync_second_len};
            end
            PH_SYNC2: begin
              ear_d      = level_q;
              level_d    = ~level_q;
              phase_d    = PH_DATA;
              byte_pos_d = 17'd0;
              bit_pos_d  = 3'd7;
              half_d     = 1'b0;
              state_d    = S_RD;
            end
            PH_DATA: begin
              ear_d   = level_q;
              level_d = ~level_q;
              if (!half_q) begin
                half_d = 1'b1;
              end else begin
                half_d = 1'b0;
                if (bit_pos_q == 3'd0) begin
                  bit_pos_d  = 3'd7;
                  byte_pos_d = byte_pos_q + 17'd1;
                end else begin
                  bit_pos_d = bit_pos_q - 3'd1;
                end
              end
              state_d = S_RD;
            end
            PH_PAUSE: begin
              ear_d   = 1'b0;
              phase_d = PH_IDLE;
              ptl_d   = 25'd0;
            end
            default: begin
              phase_d = PH_IDLE;
            end
          endcase
        end
      end
      S_RD: begin
        // Past the last byte: drop into the low pause
        if (byte_pos_q >= block_len_q) begin
          phase_d = PH_PAUSE;
          ear_d   = 1'b0;
          level_d = 1'b0;
          ptl_d   = {1'b0, cfg_i.pause_len};
          state_d = S_TICK;
        end else begin
          state_d = S_LD;
        end
      end
      S_LD: begin
        ptl_d   = rd_data_i[bit_pos_q] ? {9'd0, cfg_i.one_bit_len}
                                       : {9'd0, cfg_i.zero_bit_len};
        state_d = S_TICK;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (res_valid_d) begin
      res_d.ear_out  = ear_d;
      res_d.done_res = (phase_d == PH_IDLE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_IDLE;
      ptl_q       <= 25'd0;
      pilot_q     <= 14'd0;
      byte_pos_q  <= 17'd0;
      block_len_q <= 17'd0;
      bit_pos_q   <= 3'd7;
      half_q      <= 1'b0;
      level_q     <= 1'b1;
      ear_q       <= 1'b0;
      delta_q     <= 16'd0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      ptl_q       <= ptl_d;
      pilot_q     <= pilot_d;
      byte_pos_q  <= byte_pos_d;
      block_len_q <= block_len_d;
      bit_pos_q   <= bit_pos_d;
      half_q      <= half_d;
      level_q     <= level_d;
      ear_q       <= ear_d;
      delta_q     <= delta_d;
      res_valid_q <= res_valid_d;
      res_q       <= res_d;
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign rd_addr_o   = byte_pos_q[AW-1:0];

  a_nontick_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && state_q == S_IDLE && req_i.req_type != REQ_TICK) |=> res_valid_q)
    else $error("non-tick request gave no result beat");

  a_tick_enters_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && state_q == S_IDLE && req_i.req_type == REQ_TICK) |=> state_q == S_TICK)
    else $error("tick request did not start the timing loop");

  a_idle_no_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (ptl_q == 25'd0))
    else $error("time left while no block plays");

  a_pause_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAUSE) |-> !ear_q)
    else $error("EAR high during pause");

  a_load_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LD) |-> $past(state_q == S_RD))
    else $error("bit load without store read");

  a_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (state_q == S_IDLE))
    else $error("result beat while sequencer busy");

endmodule

[hdl/tape_block_pulse_generator_unit.sv]
// Top level: configuration registers, block byte store and pulse sequencer.
//
//  channel  | signals                          | handshake
//  ---------+----------------------------------+-----------------------------------
//  request  | start_i, busy_o, req_i           | taken when start_i && !busy_o
//  result   | res_valid_o, res_o               | one-cycle strobe, cannot be held
//  config   | cfg_we_i, cfg_idx_i, cfg_data_i  | written on any edge with cfg_we_i
//
// Start, write and unknown requests never raise busy; their result beat comes the
// cycle after. A tick holds busy while it finishes pulses, while it reads the store and
// loads each data pulse, and while it enters the pause (registered store read).
// The result beat of a tick shows in the first cycle with busy low.
// The receiver cannot stall; only the tick loop holds off the next request.
// Reset restores the register defaults and idles the tape; the byte store is not cleared.
module tape_block_pulse_generator_unit
  import tbpg_pkg::*;
#(
  parameter int unsigned BLOCK_BYTES = 65536
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  tbpg_req_t         req_i,
  output logic              res_valid_o,
  output tbpg_res_t         res_o,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(BLOCK_BYTES);

  tbpg_cfg_t        cfg_q;
  logic             store_we;
  logic [AW-1:0]    rd_addr;
  logic [7:0]       rd_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pilot_pulse_len    <= RST_PILOT_LEN;
      cfg_q.sync_first_len     <= RST_SYNC1_LEN;
      cfg_q.sync_second_len    <= RST_SYNC2_LEN;
      cfg_q.zero_bit_len       <= RST_ZERO_LEN;
      cfg_q.one_bit_len        <= RST_ONE_LEN;
      cfg_q.pause_len          <= RST_PAUSE_LEN;
      cfg_q.header_pilot_count <= RST_HDR_PILOTS;
      cfg_q.data_pilot_count   <= RST_DATA_PILOTS;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PILOT_LEN:   cfg_q.pilot_pulse_len    <= cfg_data_i[15:0];
        CFG_SYNC1_LEN:   cfg_q.sync_first_len     <= cfg_data_i[15:0];
        CFG_SYNC2_LEN:   cfg_q.sync_second_len    <= cfg_data_i[15:0];
        CFG_ZERO_LEN:    cfg_q.zero_bit_len       <= cfg_data_i[15:0];
        CFG_ONE_LEN:     cfg_q.one_bit_len        <= cfg_data_i[15:0];
        CFG_PAUSE_LEN:   cfg_q.pause_len          <= cfg_data_i[23:0];
        CFG_HDR_PILOTS:  cfg_q.header_pilot_count <= cfg_data_i[13:0];
        CFG_DATA_PILOTS: cfg_q.data_pilot_count   <= cfg_data_i[13:0];
        default: begin
        end
      endcase
    end
  end

  // Drop writes beyond the store
  assign store_we = start_i && !busy_o && (req_i.req_type == REQ_WRITE) &&
                    ({1'b0, req_i.byte_index} < 17'(BLOCK_BYTES));

  tbpg_ram #(
    .Width(8),
    .Depth(BLOCK_BYTES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (store_we),
    .waddr_i(req_i.byte_index[AW-1:0]),
    .wdata_i(req_i.byte_value),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  tbpg_core #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .cfg_i      (cfg_q),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data)
  );

endmodule

[sim/tb_tape_block_pulse_generator_unit.sv]
// Self-checking testbench for the tape block pulse generator: directed and random requests.
`timescale 1ns / 1ps

module tb_tape_block_pulse_generator_unit;
  import tbpg_pkg::*;

  localparam int unsigned BLOCK_BYTES = 65536;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int ITEM_TARGET = 1850;

  typedef enum logic [2:0] {
    TP_IDLE, TP_PILOT, TP_SYNC1, TP_SYNC2, TP_DATA, TP_PAUSE
  } tape_phase_e;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic              busy_o;
  tbpg_req_t         req_i = '0;
  logic              res_valid_o;
  tbpg_res_t         res_o;
  logic              cfg_we_i = 1'b0;
  logic [CFG_IW-1:0] cfg_idx_i = '0;
  logic [CFG_DW-1:0] cfg_data_i = '0;

  tape_block_pulse_generator_unit #(.BLOCK_BYTES(BLOCK_BYTES)) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Tape player copy: configuration, byte store and sequencer state
  tbpg_cfg_t   tape_cfg = '{RST_PILOT_LEN, RST_SYNC1_LEN, RST_SYNC2_LEN, RST_ZERO_LEN,
                            RST_ONE_LEN, RST_PAUSE_LEN, RST_HDR_PILOTS, RST_DATA_PILOTS};
  logic [7:0]  byte_mem [0:BLOCK_BYTES-1];
  tape_phase_e tape_ph = TP_IDLE;
  logic [24:0] pulse_left = '0;
  logic [13:0] pilots_left = '0;
  logic [16:0] blk_len = '0;
  logic [16:0] byte_ptr = '0;
  logic [2:0]  bit_ptr = 3'd7;
  logic        second_half = 1'b0;
  logic        tape_lvl = 1'b1;
  logic        ear_q = 1'b0;

  tbpg_req_t tape_reqs[$];
  tbpg_res_t levels_due[$];
  bit        written_map [0:BLOCK_BYTES-1];
  int        written_run = 0;
  int        beats_queued = 0;
  int        beats_taken = 0;
  int        send_gap_pct = 0;
  int        delta_cap = 65535;
  int        mismatches = 0;
  int        quiet_cycles = 0;

  function automatic void toggle_ear();
    ear_q = tape_lvl;
    tape_lvl = ~tape_lvl;
  endfunction

  function automatic void load_bit_pulse();
    if (byte_ptr >= blk_len) begin
      tape_ph = TP_PAUSE;
      ear_q = 1'b0;
      tape_lvl = 1'b0;
      pulse_left = 25'(tape_cfg.pause_len);
    end else if (byte_mem[byte_ptr[15:0]][bit_ptr]) begin
      pulse_left = 25'(tape_cfg.one_bit_len);
    end else begin
      pulse_left = 25'(tape_cfg.zero_bit_len);
    end
  endfunction

  function automatic tbpg_res_t tape_advance(tbpg_req_t r);
    logic [24:0] d;
    tbpg_res_t   res;
    case (r.req_type)
      REQ_START: begin
        blk_len = (r.block_length > BLOCK_BYTES) ? 17'(BLOCK_BYTES) : r.block_length;
        byte_ptr = '0;
        bit_ptr = 3'd7;
        second_half = 1'b0;
        pilots_left = r.hdr_blk ? tape_cfg.header_pilot_count : tape_cfg.data_pilot_count;
        if (pilots_left != 0) begin
          tape_ph = TP_PILOT;
          pulse_left = 25'(tape_cfg.pilot_pulse_len);
        end else begin
          tape_ph = TP_SYNC1;
          pulse_left = 25'(tape_cfg.sync_first_len);
        end
      end
      REQ_WRITE: byte_mem[r.byte_index] = r.byte_value;
      REQ_TICK: begin
        d = 25'(r.tick_cycles);
        // Walk every pulse boundary the tick crosses
        while (tape_ph != TP_IDLE && d >= pulse_left) begin
          d = d - pulse_left;
          pulse_left = '0;
          case (tape_ph)
            TP_PILOT: begin
              toggle_ear();
              if (pilots_left != 0) pilots_left--;
              if (pilots_left != 0) begin
                pulse_left = 25'(tape_cfg.pilot_pulse_len);
              end else begin
                tape_ph = TP_SYNC1;
                pulse_left = 25'(tape_cfg.sync_first_len);
              end
            end
            TP_SYNC1: begin
              toggle_ear();
              tape_ph = TP_SYNC2;
              pulse_left = 25'(tape_cfg.sync_second_len);
            end
            TP_SYNC2: begin
              toggle_ear();
              tape_ph = TP_DATA;
              byte_ptr = '0;
              bit_ptr = 3'd7;
              second_half = 1'b0;
              load_bit_pulse();
            end
            TP_DATA: begin
              toggle_ear();
              if (!second_half) begin
                second_half = 1'b1;
              end else begin
                second_half = 1'b0;
                if (bit_ptr == 0) begin
                  bit_ptr = 3'd7;
                  byte_ptr++;
                end else begin
                  bit_ptr--;
                end
              end
              load_bit_pulse();
            end
            default: begin
              // end of pause
              ear_q = 1'b0;
              tape_ph = TP_IDLE;
            end
          endcase
        end
        if (tape_ph != TP_IDLE) pulse_left = pulse_left - d;
      end
      default: ;
    endcase
    res.ear_out = ear_q;
    res.done_res = (tape_ph == TP_IDLE);
    return res;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Random don't-care fields around the given request code
  function automatic tbpg_req_t noise_req(logic [1:0] kind);
    logic [63:0] raw;
    tbpg_req_t   r;
    raw = {$urandom, $urandom};
    r = raw[$bits(tbpg_req_t)-1:0];
    r.req_type = kind;
    return r;
  endfunction

  function automatic void queue_req(tbpg_req_t r);
    if (r.req_type == REQ_WRITE) begin
      written_map[r.byte_index] = 1'b1;
      while (written_run < BLOCK_BYTES && written_map[written_run]) written_run++;
    end
    tape_reqs.insert(tape_reqs.size(), r);
    beats_queued++;
  endfunction

  // Keep blocks inside the written prefix so no unwritten byte is ever played
  function automatic tbpg_req_t block_start(int len_cap);
    tbpg_req_t r;
    r = noise_req(REQ_START);
    r.block_length = 17'($urandom_range(0, (len_cap < written_run) ? len_cap : written_run));
    return r;
  endfunction

  task automatic queue_blocks(input int count, input int len_cap, input int tick_cap);
    tbpg_req_t r;
    int        ticks;
    int        roll;
    int        pilots;
    for (int b = 0; b < count; b++) begin
      r = block_start(len_cap);
      queue_req(r);
      pilots = r.hdr_blk ? int'(tape_cfg.header_pilot_count) : int'(tape_cfg.data_pilot_count);
      ticks = pilots + 16 * int'(r.block_length) + 10;
      if (ticks > tick_cap) ticks = tick_cap;
      for (int t = 0; t < ticks; t++) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          r = noise_req(REQ_WRITE);
          if (roll < 6)
            r.byte_index = 16'($urandom_range(0, (written_run < 65533) ? written_run + 2 : 65535));
        end else if (roll < 10) begin
          r = noise_req(REQ_UNUSED);
        end else if (roll == 10) begin
          r = block_start(len_cap);
        end else begin
          r = noise_req(REQ_TICK);
          r.tick_cycles = 16'($urandom_range(0, delta_cap));
        end
        queue_req(r);
      end
    end
  endtask

  task automatic drain();
    while (beats_taken != beats_queued || levels_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_regs(input tbpg_cfg_t c);
    logic [CFG_DW-1:0] vals [0:7];
    logic [23:0]       junk;
    junk = 24'($urandom);
    // upper bits beyond each register's width must be dropped
    vals[CFG_PILOT_LEN]   = {junk[23:16], c.pilot_pulse_len};
    vals[CFG_SYNC1_LEN]   = {junk[15:8], c.sync_first_len};
    vals[CFG_SYNC2_LEN]   = {junk[7:0], c.sync_second_len};
    vals[CFG_ZERO_LEN]    = {junk[20:13], c.zero_bit_len};
    vals[CFG_ONE_LEN]     = {junk[11:4], c.one_bit_len};
    vals[CFG_PAUSE_LEN]   = c.pause_len;
    vals[CFG_HDR_PILOTS]  = {junk[9:0], c.header_pilot_count};
    vals[CFG_DATA_PILOTS] = {junk[23:14], c.data_pilot_count};
    for (int i = 0; i < 8; i++) begin
      @(posedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_idx_i <= i[CFG_IW-1:0];
      cfg_data_i <= vals[i];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tape_cfg = c;
  endtask

  // Request driver: hold each beat until taken
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        levels_due.insert(levels_due.size(), tape_advance(req_i));
        beats_taken++;
      end
      if (!start_i || !busy_o) begin
        if (tape_reqs.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          start_i <= 1'b1;
          req_i <= tape_reqs.pop_front();
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    tbpg_res_t want;
    if (rst_ni && res_valid_o) begin
      if (levels_due.size() == 0) begin
        flag_mismatch("result beat with nothing pending");
      end else begin
        want = levels_due.pop_front();
        if (res_o.ear_out !== want.ear_out)
          flag_mismatch($sformatf("ear_out %b, want %b", res_o.ear_out, want.ear_out));
        if (res_o.done_res !== want.done_res)
          flag_mismatch($sformatf("done_res %b, want %b", res_o.done_res, want.done_res));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || res_valid_o) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("timeout: %0d results still pending", levels_due.size());
        $display("tb_tape_block_pulse_generator_unit: errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    tbpg_cfg_t c;
    tbpg_req_t r;
    int        base;
    int        ph;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: idle ticks, odd codes, store edges, oversized and restarted blocks
    r = noise_req(REQ_TICK);
    r.tick_cycles = '0;
    queue_req(r);
    r.tick_cycles = 16'hFFFF;
    queue_req(r);
    queue_req(noise_req(REQ_UNUSED));
    for (int i = 0; i < 4; i++) begin
      r = noise_req(REQ_WRITE);
      r.byte_index = 16'(i);
      r.byte_value = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : (i == 2) ? 8'hA5 : 8'h5A;
      queue_req(r);
    end
    r = noise_req(REQ_WRITE);
    r.byte_index = 16'hFFFF;
    r.byte_value = 8'h80;
    queue_req(r);
    r = noise_req(REQ_START);
    r.hdr_blk = 1'b1;
    r.block_length = 17'h1FFFF;
    queue_req(r);
    r = noise_req(REQ_TICK);
    r.tick_cycles = 16'd100;
    queue_req(r);
    r = noise_req(REQ_START);
    r.hdr_blk = 1'b0;
    r.block_length = 17'(BLOCK_BYTES);
    queue_req(r);
    r.block_length = 17'd2;
    queue_req(r);
    r = noise_req(REQ_TICK);
    r.tick_cycles = 16'hFFFF;
    repeat (6) queue_req(r);
    delta_cap = 65535;
    queue_blocks(1, 4, 30);
    drain();

    // Zero pilot count, zero-length sync pulse and zero pause
    c = '{16'd5, 16'd0, 16'd4, 16'd2, 16'd6, 24'd0, 14'd1, 14'd0};
    load_regs(c);
    send_gap_pct = 63;
    r = noise_req(REQ_START);
    r.hdr_blk = 1'b0;
    r.block_length = '0;
    queue_req(r);
    r = noise_req(REQ_TICK);
    r.tick_cycles = '0;
    queue_req(r);
    r.tick_cycles = 16'd3;
    repeat (2) queue_req(r);
    delta_cap = 18;
    queue_blocks(3, 4, 200);
    drain();

    // Widest settings
    c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 14'h3FFF, 14'h3FFF};
    load_regs(c);
    send_gap_pct = 0;
    delta_cap = 65535;
    queue_blocks(2, 6, 40);
    drain();

    // Narrowest settings
    c = '{16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 24'd0, 14'd1, 14'd1};
    load_regs(c);
    send_gap_pct = 31;
    delta_cap = 3;
    queue_blocks(3, 6, 300);
    drain();

    ph = 4;
    while (beats_queued < ITEM_TARGET) begin
      case ($urandom_range(0, 2))
        0: base = $urandom_range(1, 4);
        1: base = $urandom_range(5, 200);
        default: base = $urandom_range(200, 21845);
      endcase
      c.pilot_pulse_len = 16'($urandom_range(base, 3 * base));
      c.sync_first_len = 16'($urandom_range(base, 3 * base));
      c.sync_second_len = 16'($urandom_range(base, 3 * base));
      c.zero_bit_len = 16'($urandom_range(base, 3 * base));
      c.one_bit_len = 16'($urandom_range(base, 3 * base));
      c.pause_len = ($urandom_range(0, 3) == 0) ? '0 : 24'($urandom_range(0, 4 * base));
      c.header_pilot_count = 14'($urandom_range(0, 12));
      c.data_pilot_count = 14'($urandom_range(0, 12));
      load_regs(c);
      case (ph % 4)
        1: send_gap_pct = 63;
        3: send_gap_pct = 31;
        default: send_gap_pct = 0;
      endcase
      delta_cap = (6 * base > 65535) ? 65535 : 6 * base;
      queue_blocks(3, 6, 300);
      drain();
      ph++;
    end

    repeat (16) @(posedge clk_i);
    if (mismatches == 0 && levels_due.size() == 0) begin
      $display("tb_tape_block_pulse_generator_unit: clean");
    end else begin
      $display("tb_tape_block_pulse_generator_unit: errors");
    end
    $finish;
  end

endmodule

[tape_block_pulse_generator_unit.f]
hdl/tbpg_pkg.sv
hdl/tbpg_ram.sv
hdl/tbpg_core.sv
hdl/tape_block_pulse_generator_unit.sv
sim/tb_tape_block_pulse_generator_unit.sv
